[src/top_pkg.sv]
// Package for the tree object parser: sizes, byte role and status codes,
// and the payload structs for the input and result channels. No dependencies.
package top_pkg;

    // Sizing of the parsed format
    localparam int MAX_ENTRIES   = 1024;
    localparam int DIGEST_BYTES  = 32;
    localparam int NAME_CAPACITY = 256;

    // Mode field holds at most this many bytes before the space
    localparam int MODE_MAX_LEN  = 15;

    localparam int FIELD_CNT_W   = 8;
    localparam int ENTRY_CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_NUM_W   = 10;
    localparam int MODE_W        = 32;

    localparam logic [FIELD_CNT_W-1:0] MODE_LAST = FIELD_CNT_W'(MODE_MAX_LEN);
    localparam logic [FIELD_CNT_W-1:0] NAME_LAST = FIELD_CNT_W'(NAME_CAPACITY - 1);
    localparam logic [FIELD_CNT_W-1:0] HASH_LAST = FIELD_CNT_W'(DIGEST_BYTES - 1);
    localparam logic [ENTRY_CNT_W-1:0] ENTRY_LIMIT = ENTRY_CNT_W'(MAX_ENTRIES);

    // Separator and digit characters
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;

    typedef enum logic [2:0] {
        ROLE_MODE = 3'd0,
        ROLE_SEP  = 3'd1,
        ROLE_NAME = 3'd2,
        ROLE_HASH = 3'd3,
        ROLE_IGN  = 3'd4
    } role_t;

    typedef enum logic [1:0] {
        STAT_CONT = 2'd0,
        STAT_OK   = 2'd1,
        STAT_FAIL = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]             byte_role;
        logic [7:0]             byte_value;
        logic [FIELD_CNT_W-1:0] field_position;
        logic [ENTRY_NUM_W-1:0] entry_number;
        logic [MODE_W-1:0]      entry_mode;
        logic                   entry_complete;
        logic [1:0]             end_status;
    } out_beat_t;

endpackage

[src/top_in_if.sv]
// Input channel of the tree object parser: valid/ready plus one byte beat.
// Depends on top_pkg for the payload type.
interface top_in_if;
    logic              valid;
    logic              ready;
    top_pkg::in_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/top_out_if.sv]
// Result channel of the tree object parser: valid/ready plus one tagged byte.
// Depends on top_pkg for the payload type.
interface top_out_if;
    logic               valid;
    logic               ready;
    top_pkg::out_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/tree_object_parser.sv]
// Top level of the tree object parser: per-byte tagging of a tree buffer.
// Depends on top_pkg, top_in_if and top_out_if.
//
// Usage:
//   in_ch carries one buffer byte per beat, with buffer_end set on the
//   final byte of a buffer. out_ch returns exactly one beat per input
//   beat: the byte's role, its offset within its field, the entry index,
//   the mode value built so far, an entry-complete flag, and on the final
//   byte the parse status (success or failure).
//   A byte accepted at a clock edge shows on out_ch right after that edge,
//   from the result register. The parser takes one byte per cycle while the
//   receiver does not stall; the parse state update is a single shallow step
//   from the state registers to the result register.
//   When the receiver stalls, the result register holds its beat and
//   in_ch.ready stays high only while that register is empty or is being
//   taken in the same cycle, so no beat is lost.
//   Reset clears the parse state to the start of a mode field and empties
//   the result register. After each final byte the parse state returns to
//   that same start, ready for the next buffer.
module tree_object_parser (
    input  logic          clk,
    input  logic          rst_n,
    top_in_if.sink        in_ch,
    top_out_if.source     out_ch
);

    typedef enum logic [1:0] {
        PH_MODE = 2'd0,
        PH_NAME = 2'd1,
        PH_HASH = 2'd2,
        PH_IDLE = 2'd3
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [top_pkg::MODE_W-1:0]         mode_acc_reg, mode_acc_next;
    logic                               mode_frozen_reg, mode_frozen_next;
    logic [top_pkg::FIELD_CNT_W-1:0]    field_cnt_reg, field_cnt_next;
    logic [top_pkg::ENTRY_CNT_W-1:0]    entries_reg, entries_next;
    logic                               failed_reg, failed_next;

    logic                               out_valid_reg;
    top_pkg::out_beat_t                 out_beat_reg, out_beat_next;

    logic                               in_fire;
    logic [7:0]                         b;
    logic                               is_octal;

    // Accept a beat while the result register is empty or draining
    assign in_ch.ready    = !out_valid_reg || out_ch.ready;
    assign in_fire        = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_beat_reg;

    assign b        = in_ch.payload.data_byte;
    assign is_octal = (b >= top_pkg::CHAR_ZERO) && (b <= top_pkg::CHAR_SEVEN);

    // Parse step for one byte
    always_comb
    begin
        phase_next       = phase_reg;
        mode_acc_next    = mode_acc_reg;
        mode_frozen_next = mode_frozen_reg;
        field_cnt_next   = field_cnt_reg;
        entries_next     = entries_reg;
        failed_next      = failed_reg;

        out_beat_next                = '0;
        out_beat_next.byte_role      = top_pkg::ROLE_IGN;
        out_beat_next.byte_value     = b;
        out_beat_next.entry_number   = entries_reg[top_pkg::ENTRY_NUM_W-1:0];
        out_beat_next.end_status     = top_pkg::STAT_CONT;

        unique case (phase_reg)
            PH_MODE:
            begin
                if (b == top_pkg::CHAR_SPACE)
                begin
                    out_beat_next.byte_role = top_pkg::ROLE_SEP;
                    phase_next              = PH_NAME;
                    field_cnt_next          = '0;
                end
                else if (field_cnt_reg >= top_pkg::MODE_LAST)
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    out_beat_next.byte_role      = top_pkg::ROLE_MODE;
                    out_beat_next.field_position = field_cnt_reg;
                    // Shift in an octal digit until the first non-octal byte
                    if (!mode_frozen_reg)
                    begin
                        if (is_octal)
                            mode_acc_next = {mode_acc_reg[top_pkg::MODE_W-4:0], b[2:0]};
                        else
                            mode_frozen_next = 1'b1;
                    end
                    field_cnt_next = field_cnt_reg + 1'b1;
                end
            end
            PH_NAME:
            begin
                if (b == top_pkg::CHAR_NUL)
                begin
                    out_beat_next.byte_role = top_pkg::ROLE_SEP;
                    phase_next              = PH_HASH;
                    field_cnt_next          = '0;
                end
                else if (field_cnt_reg >= top_pkg::NAME_LAST)
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    out_beat_next.byte_role      = top_pkg::ROLE_NAME;
                    out_beat_next.field_position = field_cnt_reg;
                    field_cnt_next               = field_cnt_reg + 1'b1;
                end
            end
            PH_HASH:
            begin
                out_beat_next.byte_role      = top_pkg::ROLE_HASH;
                out_beat_next.field_position = field_cnt_reg;
                if (field_cnt_reg >= top_pkg::HASH_LAST)
                begin
                    out_beat_next.entry_complete = 1'b1;
                    entries_next                 = entries_reg + 1'b1;
                    field_cnt_next               = '0;
                    phase_next = (entries_next >= top_pkg::ENTRY_LIMIT) ? PH_IDLE : PH_MODE;
                end
                else
                begin
                    field_cnt_next = field_cnt_reg + 1'b1;
                end
            end
            PH_IDLE:
            begin
                // Drop bytes after a failure or past the entry limit
            end
            default:
            begin
            end
        endcase

        out_beat_next.entry_mode = mode_acc_next;

        // Start the next entry's mode from zero
        if (out_beat_next.entry_complete)
        begin
            mode_acc_next    = '0;
            mode_frozen_next = 1'b0;
        end

        // Final byte: report status and return to the start of a buffer
        if (in_ch.payload.buffer_end)
        begin
            if (failed_next)
                out_beat_next.end_status = top_pkg::STAT_FAIL;
            else if (phase_next == PH_IDLE || (phase_next == PH_MODE && field_cnt_next == '0))
                out_beat_next.end_status = top_pkg::STAT_OK;
            else
                out_beat_next.end_status = top_pkg::STAT_FAIL;
            phase_next       = PH_MODE;
            mode_acc_next    = '0;
            mode_frozen_next = 1'b0;
            field_cnt_next   = '0;
            entries_next     = '0;
            failed_next      = 1'b0;
        end
    end

    // Hold parse state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MODE;
            mode_acc_reg    <= '0;
            mode_frozen_reg <= 1'b0;
            field_cnt_reg   <= '0;
            entries_reg     <= '0;
            failed_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg       <= phase_next;
                mode_acc_reg    <= mode_acc_next;
                mode_frozen_reg <= mode_frozen_next;
                field_cnt_reg   <= field_cnt_next;
                entries_reg     <= entries_next;
                failed_reg      <= failed_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result beat without reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_beat_reg <= out_beat_next;
    end

    // A failure always parks the parser until the buffer ends
    a_fail_idle: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> phase_reg == PH_IDLE)
        else $error("failed flag set outside idle phase");

    // Mode field never grows past its limit
    a_mode_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MODE |-> field_cnt_reg <= top_pkg::MODE_LAST)
        else $error("mode field counter past limit");

    // Every accepted byte yields a result beat next cycle
    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted byte produced no result");

    // Entry completion only marks hash bytes
    a_complete_hash: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_beat_reg.entry_complete
            |-> out_beat_reg.byte_role == top_pkg::ROLE_HASH)
        else $error("entry complete on non-hash byte");

endmodule

[dv/tb_tree_object_parser.sv]
// Testbench for tree_object_parser: streams tree buffers byte by byte and checks
// every tagged result beat against a local model of the parse state.
// Depends on top_pkg, top_in_if, top_out_if and the tree_object_parser RTL.
`timescale 1ns / 1ps

module tb_tree_object_parser;

    typedef enum logic [1:0] {
        FLD_MODE,
        FLD_NAME,
        FLD_HASH,
        FLD_DONE
    } field_t;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int DRAIN_CYCLES    = 10;
    localparam int MAX_PRINTED     = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    top_in_if  in_ch ();
    top_out_if out_ch ();

    tree_object_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Byte stream waiting to be driven, and tags waiting to come back
    top_pkg::in_beat_t  pending_bytes [$];
    top_pkg::out_beat_t expected_tags [$];
    logic [7:0]         tree_bytes [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off       = 1'b0;
    int phase_items    = 0;
    int mismatch_count = 0;
    int result_count   = 0;

    // Parse state of the local model
    field_t      field_state   = FLD_MODE;
    logic [31:0] mode_value    = '0;
    bit          mode_frozen   = 1'b0;
    int          field_count   = 0;
    int          entries_seen  = 0;
    bit          parse_failed  = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_parse();
        field_state  = FLD_MODE;
        mode_value   = '0;
        mode_frozen  = 1'b0;
        field_count  = 0;
        entries_seen = 0;
        parse_failed = 1'b0;
    endfunction

    // Tag one byte and advance the parse state
    function automatic top_pkg::out_beat_t tag_byte(top_pkg::in_beat_t beat);
        top_pkg::out_beat_t res;
        logic [7:0]         b;
        b = beat.data_byte;
        res = '0;
        res.byte_role    = top_pkg::ROLE_IGN;
        res.byte_value   = b;
        res.entry_number = top_pkg::ENTRY_NUM_W'(entries_seen);
        res.end_status   = top_pkg::STAT_CONT;
        case (field_state)
            FLD_MODE:
            begin
                if (b == top_pkg::CHAR_SPACE)
                begin
                    res.byte_role = top_pkg::ROLE_SEP;
                    field_state   = FLD_NAME;
                    field_count   = 0;
                end
                else if (field_count >= top_pkg::MODE_MAX_LEN)
                begin
                    parse_failed = 1'b1;
                    field_state  = FLD_DONE;
                end
                else
                begin
                    res.byte_role      = top_pkg::ROLE_MODE;
                    res.field_position = top_pkg::FIELD_CNT_W'(field_count);
                    // freeze the value at the first non-octal byte
                    if (!mode_frozen)
                    begin
                        if (b >= top_pkg::CHAR_ZERO && b <= top_pkg::CHAR_SEVEN)
                            mode_value = {mode_value[28:0], 3'b000} + {29'b0, b[2:0]};
                        else
                            mode_frozen = 1'b1;
                    end
                    field_count++;
                end
            end
            FLD_NAME:
            begin
                if (b == top_pkg::CHAR_NUL)
                begin
                    res.byte_role = top_pkg::ROLE_SEP;
                    field_state   = FLD_HASH;
                    field_count   = 0;
                end
                else if (field_count >= top_pkg::NAME_CAPACITY - 1)
                begin
                    parse_failed = 1'b1;
                    field_state  = FLD_DONE;
                end
                else
                begin
                    res.byte_role      = top_pkg::ROLE_NAME;
                    res.field_position = top_pkg::FIELD_CNT_W'(field_count);
                    field_count++;
                end
            end
            FLD_HASH:
            begin
                res.byte_role      = top_pkg::ROLE_HASH;
                res.field_position = top_pkg::FIELD_CNT_W'(field_count);
                if (field_count >= top_pkg::DIGEST_BYTES - 1)
                begin
                    res.entry_complete = 1'b1;
                    entries_seen++;
                    field_count = 0;
                    field_state = (entries_seen >= top_pkg::MAX_ENTRIES) ? FLD_DONE : FLD_MODE;
                end
                else
                    field_count++;
            end
            default: ;
        endcase
        res.entry_mode = mode_value;
        if (res.entry_complete)
        begin
            mode_value  = '0;
            mode_frozen = 1'b0;
        end
        // close the buffer on its final byte
        if (beat.buffer_end)
        begin
            if (parse_failed)
                res.end_status = top_pkg::STAT_FAIL;
            else if (field_state == FLD_DONE || (field_state == FLD_MODE && field_count == 0))
                res.end_status = top_pkg::STAT_OK;
            else
                res.end_status = top_pkg::STAT_FAIL;
            clear_parse();
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t: result %0d %s: got 0x%0h, want 0x%0h",
                     $time, result_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(top_pkg::out_beat_t got);
        top_pkg::out_beat_t want;
        if (expected_tags.size() == 0)
        begin
            report_mismatch("beat with nothing outstanding", got.byte_value, '0);
            return;
        end
        want = expected_tags.pop_front();
        if (got.byte_role !== want.byte_role)
            report_mismatch("byte_role", got.byte_role, want.byte_role);
        if (got.byte_value !== want.byte_value)
            report_mismatch("byte_value", got.byte_value, want.byte_value);
        if (got.field_position !== want.field_position)
            report_mismatch("field_position", got.field_position, want.field_position);
        if (got.entry_number !== want.entry_number)
            report_mismatch("entry_number", got.entry_number, want.entry_number);
        if (got.entry_mode !== want.entry_mode)
            report_mismatch("entry_mode", got.entry_mode, want.entry_mode);
        if (got.entry_complete !== want.entry_complete)
            report_mismatch("entry_complete", got.entry_complete, want.entry_complete);
        if (got.end_status !== want.end_status)
            report_mismatch("end_status", got.end_status, want.end_status);
        result_count++;
    endtask

    // Drive bytes: predict each accepted beat, hold an offered beat until taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.payload <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_tags.push_back(tag_byte(in_ch.payload));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_ch.valid   <= 1'b1;
                    in_ch.payload <= pending_bytes.pop_front();
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Take result beats and check them; stall at random or during a hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_result(out_ch.payload);
            out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic add_byte(logic [7:0] b);
        tree_bytes.push_back(b);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_hash();
        repeat (top_pkg::DIGEST_BYTES)
            add_byte(8'($urandom_range(0, 255)));
    endtask

    // Append one entry: mostly octal mode digits, nonzero name bytes, random hash
    task automatic add_entry(int mode_bytes, int name_bytes);
        logic [7:0] b;
        repeat (mode_bytes)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == top_pkg::CHAR_SPACE)
                    b = 8'h38;
            end
            else
                b = top_pkg::CHAR_ZERO + 8'($urandom_range(0, 7));
            add_byte(b);
        end
        add_byte(top_pkg::CHAR_SPACE);
        repeat (name_bytes)
            add_byte(8'($urandom_range(1, 255)));
        add_byte(top_pkg::CHAR_NUL);
        add_hash();
    endtask

    function automatic int pick_mode_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        else if (r < 8)
            return $urandom_range(top_pkg::MODE_MAX_LEN + 1, top_pkg::MODE_MAX_LEN + 2);
        else if (r < 16)
            return $urandom_range(8, top_pkg::MODE_MAX_LEN);
        return $urandom_range(1, 7);
    endfunction

    function automatic int pick_name_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return top_pkg::NAME_CAPACITY - 1;
        else if (r < 3)
            return top_pkg::NAME_CAPACITY;
        else if (r < 10)
            return 0;
        return $urandom_range(1, 24);
    endfunction

    // Queue the assembled buffer, marking its final byte
    task automatic send_buffer();
        top_pkg::in_beat_t beat;
        foreach (tree_bytes[i])
        begin
            beat.data_byte  = tree_bytes[i];
            beat.buffer_end = (i == tree_bytes.size() - 1);
            pending_bytes.push_back(beat);
        end
        phase_items += tree_bytes.size();
        tree_bytes.delete();
    endtask

    // Mostly well-formed buffers; some cut short mid-entry, some with trailing noise
    task automatic add_random_buffer();
        int n_entries;
        int finish_kind;
        int cut;
        n_entries   = $urandom_range(0, 3);
        finish_kind = $urandom_range(0, 9);
        repeat (n_entries)
            add_entry(pick_mode_bytes(), pick_name_bytes());
        if (finish_kind >= 6 && finish_kind <= 8)
        begin
            cut = tree_bytes.size();
            add_entry(pick_mode_bytes(), pick_name_bytes());
            cut = $urandom_range(cut + 1, tree_bytes.size() - 1);
            while (tree_bytes.size() > cut)
                void'(tree_bytes.pop_back());
        end
        else if (finish_kind == 9)
        begin
            repeat ($urandom_range(1, 8))
                add_byte(8'($urandom_range(0, 255)));
        end
        if (tree_bytes.size() == 0)
            add_entry(pick_mode_bytes(), pick_name_bytes());
        send_buffer();
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic run_random(int n_items);
        phase_items = 0;
        while (phase_items < n_items)
            add_random_buffer();
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || in_ch.valid || expected_tags.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // No idling; start with a long receiver hold-off so the input backs up
        set_idling(0, 0);
        fork
        begin
            hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
        join_none

        // widest legal mode, wrapping the accumulator; ends cleanly
        add_text("777777777777777 ");
        add_byte(top_pkg::CHAR_NUL);
        add_hash();
        send_buffer();
        // one mode byte too many fails; the rest is ignored
        add_text("1234567012345670x");
        send_buffer();
        // a non-octal digit freezes the mode value
        add_text("1807 ");
        add_byte(8'hFF);
        add_byte(top_pkg::CHAR_NUL);
        add_hash();
        send_buffer();
        // buffer ends mid-entry in each field
        add_byte(top_pkg::CHAR_SPACE);
        send_buffer();
        add_byte(top_pkg::CHAR_NUL);
        send_buffer();
        add_text("0 ab");
        send_buffer();
        add_text("0 ");
        add_byte(top_pkg::CHAR_NUL);
        add_byte(8'h00);
        send_buffer();
        // longest legal name, then one name byte too many
        add_entry(1, top_pkg::NAME_CAPACITY - 1);
        send_buffer();
        add_entry(1, top_pkg::NAME_CAPACITY);
        send_buffer();

        run_random(ITEMS_PER_PHASE);
        drain();

        set_idling(67, 0);
        run_random(ITEMS_PER_PHASE);
        drain();

        set_idling(0, 67);
        run_random(ITEMS_PER_PHASE);
        drain();

        set_idling(22, 22);
        run_random(ITEMS_PER_PHASE);
        drain();

        // let any stray beat show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_tags.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(12 * 2_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
